[sv/ted_pkg.sv]
// ---------------------------------------------------------------------------
// ted_pkg
// Shared types and constants of the threshold / erode / dilate stream block.
// ---------------------------------------------------------------------------
package ted_pkg;

    // field and register widths
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int WIN_W     = 9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

    // register reset values
    localparam logic [PIX_W-1:0] THRESHOLD_RST    = 8'd128;
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // smallest frame side in use
    localparam int MIN_DIM = 3;

    // result queue
    localparam int OQ_DEPTH = 3;
    localparam int OQ_PTR_W = 2;
    localparam int OQ_CNT_W = 2;

    // per-word control handed from the position stage to the window stage
    typedef struct packed {
        logic valid;
        logic bit_in;
        logic e_en;
        logic e_cond;
        logic out_en;
        logic on_cond;
        logic fe;
    } stage_ctl_t;

    // one result word
    typedef struct packed {
        logic pixel_on;
        logic frame_end;
    } out_word_t;

endpackage

[sv/threshold_erode_dilate_3x3.sv]
// A result word passes the stage register and the result queue; it belongs
// to the pixel 2*width+2 words before its causing word. Throughput: one word
// per cycle while the result queue has room. After a width reduction the
// next word waits while the column subtract loop folds the column into the
// new width. Reset (aresetn low, synchronous) clears counters, windows and
// queue, sets threshold 128, width 640, height 480; no clear pass.
// ---------------------------------------------------------------------------
// threshold_erode_dilate_3x3
// Gray pixel stream thresholded to a binary image, then 3x3 erosion and 3x3
// dilation through a chain of two line-buffered window cells.
// ---------------------------------------------------------------------------
module threshold_erode_dilate_3x3 #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_action,
    input  logic [ted_pkg::PIX_W-1:0]       s_pixel_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_pixel_on,
    output logic                            m_frame_end,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ted_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ted_pkg::CFG_W-1:0]       cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + MAX_WIDTH + 4);

    logic [ted_pkg::PIX_W-1:0]  threshold_reg;
    logic [ted_pkg::CFG_W-1:0]  frame_width_reg;
    logic [ted_pkg::CFG_W-1:0]  frame_height_reg;
    logic [W_W-1:0]             wid;
    logic [H_W-1:0]             hgt;
    logic [ROW_W-1:0]           rh;

    logic [COL_W-1:0]           col_reg;
    logic [COL_W-1:0]           col_next;
    logic [ROW_W-1:0]           row_reg;
    logic [ROW_W-1:0]           row_next;
    logic [W_W-1:0]             wcol;
    logic [W_W:0]               col_inc;

    logic                       norm_need;
    logic                       norm_step;
    logic                       s_accept;
    logic                       in_frame;
    logic                       ignored;
    logic                       advance;

    logic [ROW_W-1:0]           pe_row;
    logic [W_W-1:0]             pe_col;
    logic [ROW_W-1:0]           pd_row;
    logic [W_W-1:0]             pd_col;
    logic                       e_en;
    logic                       out_en;
    logic                       fe;

    ted_pkg::stage_ctl_t        b_reg;
    ted_pkg::stage_ctl_t        b_next;

    logic [ted_pkg::WIN_W-1:0]  bin_win;
    logic [ted_pkg::WIN_W-1:0]  ero_win;
    logic                       ebit;
    logic                       win_clear;
    logic                       q_push;
    ted_pkg::out_word_t         q_word;
    ted_pkg::out_word_t         head_word;
    logic [ted_pkg::OQ_CNT_W-1:0] q_count;

    // inside the one-pixel frame border
    function automatic logic is_inner(
        input logic [ROW_W-1:0] r,
        input logic [W_W-1:0]   c,
        input logic [ROW_W-1:0] h,
        input logic [W_W-1:0]   w
    );
        return (r != '0) && (({1'b0, r} + (ROW_W+1)'(2)) <= {1'b0, h})
            && (c != '0) && (({1'b0, c} + (W_W+1)'(2)) <= {1'b0, w});
    endfunction

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= ted_pkg::THRESHOLD_RST;
            frame_width_reg  <= ted_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= ted_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                ted_pkg::REG_THRESHOLD: begin
                    threshold_reg <= cfg_data[ted_pkg::PIX_W-1:0];
                end
                ted_pkg::REG_FRAME_WIDTH: begin
                    frame_width_reg <= cfg_data;
                end
                ted_pkg::REG_FRAME_HEIGHT: begin
                    frame_height_reg <= cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // saturate frame size to the supported range
    always_comb begin
        if (frame_width_reg < ted_pkg::CFG_W'(ted_pkg::MIN_DIM)) begin
            wid = W_W'(ted_pkg::MIN_DIM);
        end else if (32'(frame_width_reg) > MAX_WIDTH) begin
            wid = W_W'(MAX_WIDTH);
        end else begin
            wid = W_W'(frame_width_reg);
        end
        if (frame_height_reg < ted_pkg::CFG_W'(ted_pkg::MIN_DIM)) begin
            hgt = H_W'(ted_pkg::MIN_DIM);
        end else if (32'(frame_height_reg) > MAX_HEIGHT) begin
            hgt = H_W'(MAX_HEIGHT);
        end else begin
            hgt = H_W'(frame_height_reg);
        end
    end

    assign rh   = ROW_W'(hgt);
    assign wcol = W_W'(col_reg);

    // handshake: hold input while the column is folded into the new width or the result queue lacks room
    assign norm_need = (wcol >= wid);
    assign norm_step = s_valid && norm_need;
    assign q_push    = b_reg.valid && b_reg.out_en;
    assign s_ready   = !norm_need && (({1'b0, q_count} + 3'(q_push)) <= 3'd2);
    assign cfg_ready = !norm_step;
    assign s_accept  = s_valid && s_ready;

    // position of the current word and its erosion and dilation taps
    assign in_frame = (row_reg < rh);
    assign ignored  = s_action && in_frame;
    assign advance  = s_accept && !ignored;

    always_comb begin
        if (wcol != '0) begin
            pe_row = row_reg - ROW_W'(1);
            pe_col = wcol - W_W'(1);
        end else begin
            pe_row = row_reg - ROW_W'(2);
            pe_col = wid - W_W'(1);
        end
        if (wcol >= W_W'(2)) begin
            pd_row = row_reg - ROW_W'(2);
            pd_col = wcol - W_W'(2);
        end else if (wcol == W_W'(1)) begin
            pd_row = row_reg - ROW_W'(3);
            pd_col = wid - W_W'(1);
        end else begin
            pd_row = row_reg - ROW_W'(3);
            pd_col = wid - W_W'(2);
        end
    end

    assign e_en   = (row_reg >= ROW_W'(2)) || ((row_reg == ROW_W'(1)) && (wcol != '0));
    assign out_en = (row_reg >= ROW_W'(3)) || ((row_reg == ROW_W'(2)) && (wcol >= W_W'(2)));
    assign fe     = (pd_row >= rh)
                 || ((pd_row == (rh - ROW_W'(1))) && (pd_col == (wid - W_W'(1))));

    // column and row counters
    assign col_inc = {1'b0, wcol} + (W_W+1)'(1);

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (norm_step) begin
            col_next = COL_W'(wcol - wid);
            row_next = row_reg + ROW_W'(1);
        end else if (advance) begin
            if (out_en && fe) begin
                col_next = '0;
                row_next = '0;
            end else if (col_inc >= {1'b0, wid}) begin
                col_next = '0;
                row_next = row_reg + ROW_W'(1);
            end else begin
                col_next = COL_W'(col_inc);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // control for the window stage
    always_comb begin
        b_next.valid   = advance;
        b_next.bit_in  = in_frame && is_inner(row_reg, wcol, rh, wid)
                      && (s_pixel_value < threshold_reg);
        b_next.e_en    = e_en;
        b_next.e_cond  = (pe_row < rh) && is_inner(pe_row, pe_col, rh, wid);
        b_next.out_en  = out_en;
        b_next.on_cond = (pd_row < rh) && is_inner(pd_row, pd_col, rh, wid);
        b_next.fe      = fe;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_reg <= '0;
        end else begin
            b_reg <= b_next;
        end
    end

    // windows return to zero after the last word of a frame
    assign win_clear = b_reg.valid && b_reg.out_en && b_reg.fe;

    // threshold cell
    ted_morph_cell #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_bin_cell (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (advance),
        .rd_addr   (col_reg),
        .push      (b_reg.valid),
        .clear     (win_clear),
        .bit_in    (b_reg.bit_in),
        .win_shift (bin_win)
    );

    // erosion: all nine neighbors set
    assign ebit = b_reg.e_cond && (&bin_win);

    ted_morph_cell #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_ero_cell (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (advance && e_en),
        .rd_addr   (COL_W'(pe_col)),
        .push      (b_reg.valid && b_reg.e_en),
        .clear     (win_clear),
        .bit_in    (ebit),
        .win_shift (ero_win)
    );

    // dilation: any eroded neighbor set
    assign q_word.pixel_on  = b_reg.on_cond && (|ero_win);
    assign q_word.frame_end = b_reg.fe;

    ted_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_word (q_word),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .head_word (head_word),
        .count     (q_count)
    );

    assign m_pixel_on  = head_word.pixel_on;
    assign m_frame_end = head_word.frame_end;

`ifndef NO_ASSERTIONS
    // a word is only taken with its column inside the current width
    a_col_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |-> (wcol < wid))
        else $error("word accepted with column outside width");

    // result queue never overflows
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && !(m_valid && m_ready)) |-> (q_count != 2'd3))
        else $error("result queue overflow");

    // every result comes from a word that also stepped the erosion window
    a_out_has_erode: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> b_reg.e_en)
        else $error("result without erosion step");

    // frame end returns the position counters to the frame start
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && out_en && fe) |=> ((col_reg == '0) && (row_reg == '0)))
        else $error("counters not cleared at frame end");
`endif

endmodule

[sv/ted_morph_cell.sv]
// ---------------------------------------------------------------------------
// ted_morph_cell
// One 3x3 window cell: two-row line store of one bit per column plus the
// window register. Read is issued the cycle before the push; the push shifts
// a new column into the window and rotates the line store entry.
// ---------------------------------------------------------------------------
module ted_morph_cell #(
    parameter int DEPTH  = 1024,
    parameter int ADDR_W = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    input  logic                       push,
    input  logic                       clear,
    input  logic                       bit_in,
    output logic [ted_pkg::WIN_W-1:0]  win_shift
);

    // entry bit 1 is the row two above, bit 0 the row just above
    logic [1:0]                 rows_mem [DEPTH];
    logic [1:0]                 rd_reg;
    logic [ADDR_W-1:0]          addr_reg;
    logic [ted_pkg::WIN_W-1:0]  win_reg;
    logic [ted_pkg::WIN_W-1:0]  win_next;

    // line store: registered read, write back on push
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_reg   <= rows_mem[rd_addr];
            addr_reg <= rd_addr;
        end
        if (push) begin
            rows_mem[addr_reg] <= {rd_reg[0], bit_in};
        end
    end

    // new column enters at the top bits: current row in the MSB, then the row above, then the row two above
    assign win_shift = {bit_in, rd_reg[0], rd_reg[1], win_reg[ted_pkg::WIN_W-1:3]};

    always_comb begin
        win_next = win_reg;
        if (clear) begin
            win_next = '0;
        end else if (push) begin
            win_next = win_shift;
        end
    end

    // window register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_reg <= '0;
        end else begin
            win_reg <= win_next;
        end
    end

endmodule

[sv/ted_outq.sv]
// ---------------------------------------------------------------------------
// ted_outq
// Three-entry result queue between the window stage and the output channel.
// ---------------------------------------------------------------------------
module ted_outq (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              push,
    input  ted_pkg::out_word_t                push_word,
    input  logic                              m_ready,
    output logic                              m_valid,
    output ted_pkg::out_word_t                head_word,
    output logic [ted_pkg::OQ_CNT_W-1:0]      count
);

    ted_pkg::out_word_t                q_mem [ted_pkg::OQ_DEPTH];
    logic [ted_pkg::OQ_PTR_W-1:0]      wr_ptr_reg;
    logic [ted_pkg::OQ_PTR_W-1:0]      wr_ptr_next;
    logic [ted_pkg::OQ_PTR_W-1:0]      rd_ptr_reg;
    logic [ted_pkg::OQ_PTR_W-1:0]      rd_ptr_next;
    logic [ted_pkg::OQ_CNT_W-1:0]      count_reg;
    logic [ted_pkg::OQ_CNT_W-1:0]      count_next;
    logic                              pop;

    function automatic logic [ted_pkg::OQ_PTR_W-1:0] ptr_inc(
        input logic [ted_pkg::OQ_PTR_W-1:0] p
    );
        if (p == ted_pkg::OQ_PTR_W'(ted_pkg::OQ_DEPTH - 1)) begin
            return '0;
        end
        return p + ted_pkg::OQ_PTR_W'(1);
    endfunction

    assign m_valid   = (count_reg != '0);
    assign head_word = q_mem[rd_ptr_reg];
    assign count     = count_reg;
    assign pop       = m_valid && m_ready;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + ted_pkg::OQ_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - ted_pkg::OQ_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= push_word;
        end
    end

endmodule

[tb/tb_threshold_erode_dilate_3x3.sv]
// ---------------------------------------------------------------------------
// tb_threshold_erode_dilate_3x3
// Self-checking bench for the threshold / erode / dilate stream block. A
// software copy of the binary opening predicts each result word from the
// accepted words; the result port is checked against it field by field,
// under random idling on both sides and register changes between phases.
// ---------------------------------------------------------------------------
module tb_threshold_erode_dilate_3x3;
    timeunit 1ns;
    timeprecision 1ps;

    import ted_pkg::*;

    localparam int MAX_W = 1024;
    localparam int MAX_H = 1024;
    localparam int SETTLE = 8;
    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic                 s_action;
    logic [PIX_W-1:0]     s_pixel_value;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_pixel_on;
    logic                 m_frame_end;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    threshold_erode_dilate_3x3 #(
        .MAX_WIDTH  (MAX_W),
        .MAX_HEIGHT (MAX_H)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pixel_on    (m_pixel_on),
        .m_frame_end   (m_frame_end),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow registers and opening state
    logic [PIX_W-1:0] thr_reg;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    bit               bin_rows [0:2*MAX_W-1];
    bit               ero_rows [0:2*MAX_W-1];
    logic [WIN_W-1:0] bin_win;
    logic [WIN_W-1:0] ero_win;
    int unsigned      col_pos;
    int unsigned      row_pos;

    out_word_t   pending_pixels[$];
    int unsigned frames_predicted;
    int unsigned words_used;
    int unsigned words_dropped;
    int unsigned results_checked;
    int unsigned frame_ends_seen;
    int unsigned fg_seen;
    int unsigned fail_count;
    int unsigned cycle_count;

    // idling control, percent chance of a burst
    int unsigned tx_gap_pct;
    int unsigned rx_stall_pct;

    // clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int unsigned dim_in_use(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic bit inner_pos(input int unsigned p, input int unsigned w,
                                     input int unsigned h);
        int unsigned r;
        int unsigned c;
        r = p / w;
        c = p % w;
        return (r >= 1) && (r + 2 <= h) && (c >= 1) && (c + 2 <= w);
    endfunction

    function automatic void clear_opening_state();
        thr_reg    = THRESHOLD_RST;
        width_reg  = FRAME_WIDTH_RST;
        height_reg = FRAME_HEIGHT_RST;
        foreach (bin_rows[i]) begin
            bin_rows[i] = 1'b0;
            ero_rows[i] = 1'b0;
        end
        bin_win = '0;
        ero_win = '0;
        col_pos = 0;
        row_pos = 0;
    endfunction

    function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_W-1:0] data);
        case (idx)
            REG_THRESHOLD:    thr_reg = data[PIX_W-1:0];
            REG_FRAME_WIDTH:  width_reg = data;
            REG_FRAME_HEIGHT: height_reg = data;
            default: ;
        endcase
    endfunction

    // push one bit through a line store pair and its 3x3 window
    function automatic logic [WIN_W-1:0] slide(input bit eroded, input logic [WIN_W-1:0] win,
                                               input int unsigned col, input bit b);
        bit top;
        bit mid;
        if (eroded) begin
            top = ero_rows[MAX_W + col];
            mid = ero_rows[col];
            ero_rows[MAX_W + col] = mid;
            ero_rows[col] = b;
        end else begin
            top = bin_rows[MAX_W + col];
            mid = bin_rows[col];
            bin_rows[MAX_W + col] = mid;
            bin_rows[col] = b;
        end
        return {b, mid, top, win[WIN_W-1:3]};
    endfunction

    // one accepted word through threshold, erosion and dilation
    function automatic bit opening_step(input bit act, input logic [PIX_W-1:0] pix,
                                        output out_word_t res, output bit dropped);
        int unsigned w;
        int unsigned h;
        int unsigned total;
        int unsigned t;
        int unsigned pe;
        int unsigned pd;
        bit          b;
        bit          eb;
        w = dim_in_use(width_reg, MAX_W);
        h = dim_in_use(height_reg, MAX_H);
        total = w * h;
        res = '0;
        dropped = 1'b0;
        if (col_pos >= w) begin
            row_pos += col_pos / w;
            col_pos = col_pos % w;
        end
        t = row_pos * w + col_pos;
        // flush before the last pixel of the frame does nothing
        if (act && t < total) begin
            dropped = 1'b1;
            return 1'b0;
        end
        b = (t < total) && inner_pos(t, w, h) && (pix < thr_reg);
        bin_win = slide(1'b0, bin_win, col_pos, b);
        if (t >= w + 1) begin
            pe = t - w - 1;
            eb = (pe < total) && inner_pos(pe, w, h) && (bin_win == '1);
            ero_win = slide(1'b1, ero_win, pe % w, eb);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
        end
        if (t >= 2 * w + 2) begin
            pd = t - 2 * w - 2;
            res.pixel_on  = (pd < total) && inner_pos(pd, w, h) && (ero_win != '0);
            res.frame_end = (pd + 1 >= total);
            if (res.frame_end) begin
                col_pos = 0;
                row_pos = 0;
                bin_win = '0;
                ero_win = '0;
            end
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // raster position the next word will take
    function automatic int unsigned next_raster(input int unsigned w);
        return (row_pos + col_pos / w) * w + col_pos % w;
    endfunction

    function automatic logic [PIX_W-1:0] gray_level(input bit dark);
        if (dark && thr_reg != 0) return PIX_W'($urandom_range(0, thr_reg - 1));
        return PIX_W'($urandom_range(thr_reg, 255));
    endfunction

    function automatic logic [CFG_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return CFG_W'($urandom_range(0, 2));
        if (r < 15) return CFG_W'($urandom_range(13, 24));
        return CFG_W'($urandom_range(3, 12));
    endfunction

    // prediction on accept, then check of the result port
    always @(posedge aclk) begin : watch_ports
        out_word_t want;
        out_word_t got;
        bit        dropped;
        if (!aresetn) begin
            clear_opening_state();
        end else begin
            if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                if (opening_step(s_action, s_pixel_value, want, dropped)) begin
                    pending_pixels.push_back(want);
                    frames_predicted += want.frame_end;
                end
                if (dropped) words_dropped++;
                else words_used++;
            end
            if (m_valid === 1'b1 && m_ready) begin
                got.pixel_on  = m_pixel_on;
                got.frame_end = m_frame_end;
                if (pending_pixels.size() == 0) begin
                    $error("unexpected result word: pixel_on %0b frame_end %0b",
                           got.pixel_on, got.frame_end);
                    fail_count++;
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.pixel_on !== want.pixel_on) begin
                        $error("pixel_on: expected %0b, actual %0b", want.pixel_on, got.pixel_on);
                        fail_count++;
                    end
                    if (got.frame_end !== want.frame_end) begin
                        $error("frame_end: expected %0b, actual %0b",
                               want.frame_end, got.frame_end);
                        fail_count++;
                    end
                end
                results_checked++;
                frame_ends_seen += got.frame_end;
                fg_seen += got.pixel_on;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side backpressure
    initial begin : result_sink
        int unsigned n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
                n = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
            end
            n = $urandom_range(1, 13);
            m_ready <= 1'b1;
            repeat (n) @(negedge aclk);
        end
    end

    // send one word; starts and ends at a falling edge, leaves valid high
    task automatic send_word(input bit act, input logic [PIX_W-1:0] pix);
        if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_pixel_value <= pix;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
    endtask

    // sender holds off until every pending result is out and the pipe is quiet
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // feed pixels and then flushes until the word giving the frame end is accepted
    task automatic run_frame(input int unsigned dark_pct, input int unsigned early_pct,
                             input int unsigned drain_pix_pct);
        int unsigned ends0;
        int unsigned w;
        int unsigned h;
        ends0 = frames_predicted;
        while (frames_predicted == ends0) begin
            w = dim_in_use(width_reg, MAX_W);
            h = dim_in_use(height_reg, MAX_H);
            if (next_raster(w) < w * h) begin
                if (early_pct != 0 && $urandom_range(0, 99) < early_pct)
                    send_word(1'b1, PIX_W'($urandom));
                else
                    send_word(1'b0, gray_level($urandom_range(0, 99) < dark_pct));
            end else begin
                // a pixel word past the last pixel drains like a flush
                if (drain_pix_pct != 0 && $urandom_range(0, 99) < drain_pix_pct)
                    send_word(1'b0, PIX_W'($urandom));
                else
                    send_word(1'b1, PIX_W'($urandom));
            end
        end
    endtask

    task automatic shuffle_idling();
        tx_gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
        rx_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
    endtask

    // threshold left at its reset value, 127 dark and 128 not
    task automatic test_reset_threshold();
        int unsigned r;
        int unsigned c;
        shuffle_idling();
        set_size(CFG_W'(5), CFG_W'(5));
        for (int i = 0; i < 25; i++) begin
            r = i / 5;
            c = i % 5;
            // border is background even when dark
            if (r == 0 || r == 4 || c == 0 || c == 4) send_word(1'b0, (i % 2) ? 8'd255 : 8'd0);
            else send_word(1'b0, 8'd127);
        end
        run_frame(0, 0, 0);
        for (int i = 0; i < 25; i++) send_word(1'b0, (i == 12) ? 8'd128 : 8'd127);
        run_frame(0, 0, 0);
        wait_idle();
    endtask

    // threshold extremes, early flush, smallest frame drained by pixel words
    task automatic test_thresholds();
        write_reg(REG_THRESHOLD, CFG_W'(0));
        send_word(1'b1, 8'hFF);
        for (int i = 0; i < 25; i++) begin
            if (i == 13) send_word(1'b1, 8'h00);
            send_word(1'b0, 8'd0);
        end
        run_frame(0, 0, 0);
        wait_idle();
        // upper data bits are dropped, threshold lands at 255
        write_reg(REG_THRESHOLD, 11'h7FF);
        for (int i = 0; i < 25; i++) send_word(1'b0, (i % 5 == 0) ? 8'd255 : 8'd254);
        run_frame(0, 0, 0);
        wait_idle();
        write_reg(REG_UNUSED, CFG_W'($urandom));
        set_size(CFG_W'(0), CFG_W'(2));
        run_frame(50, 0, 100);
        wait_idle();
    endtask

    // width saturates to the maximum; this also fills every line store entry
    task automatic test_max_width();
        tx_gap_pct   = 3;
        rx_stall_pct = 3;
        write_reg(REG_THRESHOLD, CFG_W'($urandom));
        set_size(11'h7FF, CFG_W'(3));
        run_frame(70, 0, 0);
        wait_idle();
    endtask

    task automatic test_max_height();
        tx_gap_pct   = 3;
        rx_stall_pct = 3;
        set_size(CFG_W'(3), 11'h7FF);
        run_frame(70, 0, 0);
        wait_idle();
    endtask

    // sizes changed part way through a frame
    task automatic test_size_change();
        shuffle_idling();
        write_reg(REG_THRESHOLD, CFG_W'(128));
        set_size(CFG_W'(8), CFG_W'(8));
        repeat (30) send_word(1'b0, gray_level($urandom_range(0, 99) < 85));
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(5));
        run_frame(85, 0, 0);
        wait_idle();
        // shrink so the position lies past the frame end
        set_size(CFG_W'(8), CFG_W'(8));
        repeat (60) send_word(1'b0, gray_level($urandom_range(0, 99) < 85));
        wait_idle();
        set_size(CFG_W'(4), CFG_W'(3));
        run_frame(85, 0, 0);
        wait_idle();
        // grow mid-frame
        set_size(CFG_W'(5), CFG_W'(6));
        repeat (12) send_word(1'b0, gray_level($urandom_range(0, 99) < 85));
        wait_idle();
        set_size(CFG_W'(9), CFG_W'(7));
        run_frame(85, 0, 0);
        wait_idle();
    endtask

    // random frames, mostly well formed, some noisy or cut short
    task automatic test_random_frames(input int unsigned goal);
        int unsigned base;
        int unsigned kind;
        int unsigned sel;
        int unsigned dark;
        int unsigned total;
        base = words_used;
        while (words_used - base < goal) begin
            shuffle_idling();
            sel = $urandom_range(0, 9);
            if (sel == 0) write_reg(REG_THRESHOLD, {3'($urandom), 8'h00});
            else if (sel == 1) write_reg(REG_THRESHOLD, {3'($urandom), 8'hFF});
            else write_reg(REG_THRESHOLD, CFG_W'($urandom));
            if ($urandom_range(0, 4) != 0) write_reg(REG_FRAME_WIDTH, pick_dim());
            if ($urandom_range(0, 4) != 0) write_reg(REG_FRAME_HEIGHT, pick_dim());
            if ($urandom_range(0, 9) == 0) write_reg(REG_UNUSED, CFG_W'($urandom));
            dark = $urandom_range(50, 100);
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                total = dim_in_use(width_reg, MAX_W) * dim_in_use(height_reg, MAX_H);
                repeat ($urandom_range(1, total - 1))
                    send_word(1'b0, gray_level($urandom_range(0, 99) < dark));
                wait_idle();
                write_reg(REG_FRAME_WIDTH, pick_dim());
                write_reg(REG_FRAME_HEIGHT, pick_dim());
                run_frame(dark, 0, 0);
            end else if (kind == 1) begin
                run_frame(dark, 10, 30);
            end else begin
                run_frame(dark, 0, 0);
            end
            wait_idle();
        end
    endtask

    // closing stretch at full rate on both sides
    task automatic test_quiet_tail();
        tx_gap_pct   = 0;
        rx_stall_pct = 0;
        repeat (3) begin
            write_reg(REG_THRESHOLD, CFG_W'($urandom));
            set_size(CFG_W'($urandom_range(5, 12)), CFG_W'($urandom_range(5, 12)));
            run_frame(80, 0, 0);
            wait_idle();
        end
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_action      = 1'b0;
        s_pixel_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        tx_gap_pct    = 0;
        rx_stall_pct  = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_threshold();
        test_thresholds();
        test_max_width();
        test_max_height();
        test_size_change();
        test_random_frames(1300);
        test_quiet_tail();

        wait_idle();
        repeat (SETTLE) @(negedge aclk);
        $display("covered %0d pixel/flush words (%0d ignored), %0d frames incl. 1024 wide and tall",
                 words_used + words_dropped, words_dropped, frame_ends_seen);
        $display("checked %0d result words, %0d of them foreground", results_checked, fg_seen);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
